FILE: src/lcfr_pkg.sv
// Shared types, constants and the CRC-32 byte update for the frame receiver.
`timescale 1ns / 1ps
`default_nettype none

package lcfr_pkg;

  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  localparam int QUEUE_DEPTH_DEFAULT = 4;

  typedef struct packed {
    logic        kind;
    logic [7:0]  data;
    logic        last;
    logic [31:0] length;
    logic [31:0] crc_rx;
  } entry_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: src/lcfr_front.sv
// Front end: tracks the frame phase and classifies each received byte.
`timescale 1ns / 1ps
`default_nettype none

module lcfr_front
  import lcfr_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] rx_byte,
  input  wire logic       q_full,
  output logic            q_push,
  output entry_t          q_entry
);

  typedef enum logic [2:0] {
    PH_HEADER  = 3'b001,
    PH_PAYLOAD = 3'b010,
    PH_TRAILER = 3'b100
  } phase_t;

  phase_t      phase, phase_next;
  logic [1:0]  header_count, header_count_next;
  logic [31:0] length_value, length_value_next;
  logic [31:0] bytes_left, bytes_left_next;
  logic [31:0] crc_received, crc_received_next;
  logic        accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  always_comb begin
    phase_next        = phase;
    header_count_next = header_count;
    length_value_next = length_value;
    bytes_left_next   = bytes_left;
    crc_received_next = crc_received;
    q_push            = 1'b0;
    q_entry           = '0;
    if (accept) begin
      unique case (phase)
        PH_PAYLOAD: begin
          bytes_left_next = bytes_left - 32'd1;
          q_push          = 1'b1;
          q_entry.kind    = KIND_PAYLOAD;
          q_entry.data    = rx_byte;
          q_entry.last    = (bytes_left == 32'd1);
          if (bytes_left == 32'd1) begin
            phase_next        = PH_TRAILER;
            header_count_next = 2'd0;
          end
        end
        PH_TRAILER: begin
          crc_received_next = {crc_received[23:0], rx_byte};
          if (header_count == 2'd3) begin
            q_push            = 1'b1;
            q_entry.kind      = KIND_STATUS;
            q_entry.length    = length_value;
            q_entry.crc_rx    = crc_received_next;
            phase_next        = PH_HEADER;
            header_count_next = 2'd0;
            length_value_next = 32'd0;
            bytes_left_next   = 32'd0;
            crc_received_next = 32'd0;
          end else begin
            header_count_next = header_count + 2'd1;
          end
        end
        default: begin
          length_value_next = {length_value[23:0], rx_byte};
          if (header_count == 2'd3) begin
            header_count_next = 2'd0;
            crc_received_next = 32'd0;
            bytes_left_next   = length_value_next;
            phase_next        = (length_value_next == 32'd0) ? PH_TRAILER : PH_PAYLOAD;
          end else begin
            phase_next        = PH_HEADER;
            header_count_next = header_count + 2'd1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HEADER;
      header_count <= 2'd0;
      length_value <= 32'd0;
      bytes_left   <= 32'd0;
      crc_received <= 32'd0;
    end else begin
      phase        <= phase_next;
      header_count <= header_count_next;
      length_value <= length_value_next;
      bytes_left   <= bytes_left_next;
      crc_received <= crc_received_next;
    end
  end

endmodule

`default_nettype wire

FILE: src/lcfr_queue.sv
// Small register queue that carries classified transactions from front to back.
`timescale 1ns / 1ps
`default_nettype none

module lcfr_queue
  import lcfr_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   push,
  input  wire entry_t push_entry,
  output logic        full,
  input  wire logic   pop,
  output logic        q_valid,
  output entry_t      head
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t             entries [DEPTH];
  logic [IDX_W-1:0]   wr_ptr, rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_push, do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign q_valid = (count != '0);
  assign head    = entries[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr + IDX_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr + IDX_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

FILE: src/lcfr_back.sv
// Back end: updates the CRC, checks the trailer and holds the output register.
`timescale 1ns / 1ps
`default_nettype none

module lcfr_back
  import lcfr_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   q_valid,
  input  wire entry_t head,
  output logic        pop,
  output logic        out_valid,
  input  wire logic   out_stall,
  output logic        kind,
  output logic [7:0]  payload_byte,
  output logic        payload_last,
  output logic [31:0] frame_length,
  output logic        crc_match
);

  logic [31:0] crc_running;

  assign pop = q_valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      crc_running <= CRC_INIT;
    end else begin
      if (pop) begin
        out_valid <= 1'b1;
        if (head.kind == KIND_STATUS) begin
          crc_running <= CRC_INIT;
        end else begin
          crc_running <= crc_byte(crc_running, head.data);
        end
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      kind <= head.kind;
      if (head.kind == KIND_STATUS) begin
        payload_byte <= 8'd0;
        payload_last <= 1'b0;
        frame_length <= head.length;
        crc_match    <= ((crc_running ^ CRC_INIT) == head.crc_rx);
      end else begin
        payload_byte <= head.data;
        payload_last <= head.last;
        frame_length <= 32'd0;
        crc_match    <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

FILE: src/length_crc_frame_receiver.sv
// Top level of the length-prefixed frame receiver with CRC-32 trailer check.
//
//   Channel | Handshake            | Payload
//   --------+----------------------+-----------------------------------------------
//   in      | in_valid / in_stall  | rx_byte
//   out     | out_valid / out_stall| kind, payload_byte, payload_last,
//           |                      | frame_length, crc_match
//
// One byte is accepted per cycle while the queue has room; each payload byte and
// the last trailer byte give a result through the queue and output register.
// The back end updates the CRC one byte at a time.
// Reset clears the frame phase, the queue and the output valid.
// A stall on the output fills the queue, after which in_stall rises.
`timescale 1ns / 1ps
`default_nettype none

module length_crc_frame_receiver
  import lcfr_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  rx_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             kind,
  output logic [7:0]       payload_byte,
  output logic             payload_last,
  output logic [31:0]      frame_length,
  output logic             crc_match
);

  entry_t push_entry, head;
  logic   push, full, pop, q_valid;

  lcfr_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .rx_byte  (rx_byte),
    .q_full   (full),
    .q_push   (push),
    .q_entry  (push_entry)
  );

  lcfr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (full),
    .pop        (pop),
    .q_valid    (q_valid),
    .head       (head)
  );

  lcfr_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .head         (head),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .kind         (kind),
    .payload_byte (payload_byte),
    .payload_last (payload_last),
    .frame_length (frame_length),
    .crc_match    (crc_match)
  );

endmodule

`default_nettype wire
